/* hw/rtl/md5_pkg.sv */
// MD5 byte-stream hash: shared types, round constants and index helpers.
// Used by md5_ctrl, md5_dp and md5_byte_stream_hash; depends on nothing.
`default_nettype none

package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_half;
    logic        last_half;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_OUT0,
    ST_OUT1
  } state_e;

  // Source of the byte written into the block store
  typedef enum logic [1:0] {
    WSEL_DATA,
    WSEL_PAD,
    WSEL_ZERO,
    WSEL_LEN
  } wsel_e;

  typedef struct packed {
    logic  wr_en;
    wsel_e wsel;
    logic  comp_start;
    logic  round_en;
    logic  fold;
    logic  msg_clear;
    logic  out_half;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       round_last;
  } dp_sts_t;

  localparam logic [5:0] PosLast = 6'd63;
  localparam logic [5:0] PosLen  = 6'd56;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [31:0] KTab [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotTab [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by round i; all arithmetic wraps at 16
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    unique case (i[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'((lo << 2) + lo + 4'd1);
      2'd2:    g = 4'((lo << 1) + lo + 4'd5);
      default: g = 4'((lo << 3) - lo);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/md5_ctrl.sv */
// MD5 controller: sequences byte loading, padding, compression and digest output.
// Depends on md5_pkg; drives md5_dp through a command struct.
`default_nettype none

module md5_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  input  wire                     in_has_byte_i,
  input  wire                     in_is_last_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output md5_pkg::ctrl_cmd_t      cmd_o,
  input  wire md5_pkg::dp_sts_t   sts_i
);

  md5_pkg::state_e state_q, state_d;
  md5_pkg::state_e ret_q, ret_d;

  logic pos_last;
  logic pos_len;

  assign pos_last = (sts_i.pos == md5_pkg::PosLast);
  assign pos_len  = (sts_i.pos == md5_pkg::PosLen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md5_pkg::ST_IDLE;
      ret_q   <= md5_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state; ret holds where to resume after a block compression
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_has_byte_i && pos_last) begin
            state_d = md5_pkg::ST_PREP;
            ret_d   = in_is_last_i ? md5_pkg::ST_PAD80 : md5_pkg::ST_IDLE;
          end else if (in_is_last_i) begin
            state_d = md5_pkg::ST_PAD80;
          end
        end
      end
      md5_pkg::ST_PAD80: begin
        if (pos_last) begin
          state_d = md5_pkg::ST_PREP;
          ret_d   = md5_pkg::ST_PADZ;
        end else begin
          state_d = md5_pkg::ST_PADZ;
        end
      end
      md5_pkg::ST_PADZ: begin
        if (pos_len) begin
          state_d = md5_pkg::ST_PADLEN;
        end else if (pos_last) begin
          state_d = md5_pkg::ST_PREP;
          ret_d   = md5_pkg::ST_PADZ;
        end
      end
      md5_pkg::ST_PADLEN: begin
        if (pos_last) begin
          state_d = md5_pkg::ST_PREP;
          ret_d   = md5_pkg::ST_OUT0;
        end
      end
      md5_pkg::ST_PREP:  state_d = md5_pkg::ST_ROUND;
      md5_pkg::ST_ROUND: begin
        if (sts_i.round_last) state_d = md5_pkg::ST_FOLD;
      end
      md5_pkg::ST_FOLD:  state_d = ret_q;
      md5_pkg::ST_OUT0: begin
        if (!out_stall_i) state_d = md5_pkg::ST_OUT1;
      end
      md5_pkg::ST_OUT1: begin
        if (!out_stall_i) state_d = md5_pkg::ST_IDLE;
      end
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.wsel  = md5_pkg::WSEL_DATA;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      md5_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.wr_en = in_valid_i && in_has_byte_i;
      end
      md5_pkg::ST_PAD80: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = md5_pkg::WSEL_PAD;
      end
      md5_pkg::ST_PADZ: begin
        cmd_o.wr_en = !pos_len;
        cmd_o.wsel  = md5_pkg::WSEL_ZERO;
      end
      md5_pkg::ST_PADLEN: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = md5_pkg::WSEL_LEN;
      end
      md5_pkg::ST_PREP:  cmd_o.comp_start = 1'b1;
      md5_pkg::ST_ROUND: cmd_o.round_en   = 1'b1;
      md5_pkg::ST_FOLD:  cmd_o.fold       = 1'b1;
      md5_pkg::ST_OUT0:  out_valid_o      = 1'b1;
      md5_pkg::ST_OUT1: begin
        out_valid_o     = 1'b1;
        cmd_o.out_half  = 1'b1;
        cmd_o.msg_clear = !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

`ifndef SYNTHESIS
  a_fold_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == md5_pkg::ST_FOLD) |=> (state_q == $past(ret_q)))
    else $error("fold did not resume at saved state");

  a_round_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == md5_pkg::ST_ROUND && !sts_i.round_last) |=> (state_q == md5_pkg::ST_ROUND))
    else $error("compression left before last round");

  a_out_after_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == md5_pkg::ST_OUT0 && $past(state_q) != md5_pkg::ST_OUT0)
      |-> ($past(state_q) == md5_pkg::ST_FOLD))
    else $error("digest shown without a finished compression");

  a_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == md5_pkg::ST_PADLEN) |-> (sts_i.pos[5:3] == 3'b111))
    else $error("length bytes written outside the block tail");
`endif

endmodule

`default_nettype wire

/* hw/rtl/md5_dp.sv */
// MD5 datapath: block store, bit counter, round unit and chaining words.
// Depends on md5_pkg; commanded by md5_ctrl.
`default_nettype none

module md5_dp (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire  [7:0]               data_byte_i,
  input  wire md5_pkg::ctrl_cmd_t  cmd_i,
  output md5_pkg::dp_sts_t         sts_o,
  output md5_pkg::out_item_t       out_data_o
);

  logic [5:0]  pos_q;
  logic [63:0] cnt_q;
  logic [5:0]  idx_q;
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;

  // 16 words of 4 bytes, little-endian byte lanes
  logic [31:0] word_mem [16];
  logic [31:0] rd_q;
  logic [3:0]  rd_addr;
  logic [7:0]  wbyte;

  logic [1:0]  stage;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] b_new;
  logic [5:0]  idx_nxt;

  always_comb begin
    unique case (cmd_i.wsel)
      md5_pkg::WSEL_DATA: wbyte = data_byte_i;
      md5_pkg::WSEL_PAD:  wbyte = md5_pkg::PadByte;
      md5_pkg::WSEL_ZERO: wbyte = 8'h00;
      default:            wbyte = cnt_q[{pos_q[2:0], 3'b000} +: 8];
    endcase
  end

  // Prefetch the word for the next round
  assign idx_nxt = idx_q + 6'd1;
  assign rd_addr = cmd_i.comp_start ? 4'd0 : md5_pkg::msg_index(idx_nxt);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      word_mem[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= wbyte;
    end
    rd_q <= word_mem[rd_addr];
  end

  assign stage = idx_q[5:4];

  always_comb begin
    unique case (stage)
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (d_q & b_q) | (~d_q & c_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign sum   = a_q + f + md5_pkg::KTab[idx_q] + rd_q;
  assign b_new = b_q + md5_pkg::rotl32(sum, md5_pkg::RotTab[{stage, idx_q[1:0]}]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (cmd_i.round_en) begin
      a_q <= d_q;
      b_q <= b_new;
      c_q <= b_q;
      d_q <= c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      chain_q[0] <= md5_pkg::InitA;
      chain_q[1] <= md5_pkg::InitB;
      chain_q[2] <= md5_pkg::InitC;
      chain_q[3] <= md5_pkg::InitD;
    end else begin
      if (cmd_i.wr_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (cmd_i.wr_en && cmd_i.wsel == md5_pkg::WSEL_DATA) begin
        cnt_q <= cnt_q + 64'd8;
      end
      if (cmd_i.comp_start) begin
        idx_q <= '0;
      end else if (cmd_i.round_en) begin
        idx_q <= idx_nxt;
      end
      if (cmd_i.msg_clear) begin
        cnt_q      <= '0;
        chain_q[0] <= md5_pkg::InitA;
        chain_q[1] <= md5_pkg::InitB;
        chain_q[2] <= md5_pkg::InitC;
        chain_q[3] <= md5_pkg::InitD;
      end else if (cmd_i.fold) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end
    end
  end

  assign sts_o.pos        = pos_q;
  assign sts_o.round_last = (idx_q == md5_pkg::PosLast);

  assign out_data_o.digest_half = cmd_i.out_half ? {chain_q[3], chain_q[2]}
                                                 : {chain_q[1], chain_q[0]};
  assign out_data_o.last_half   = cmd_i.out_half;

endmodule

`default_nettype wire

/* hw/rtl/md5_byte_stream_hash.sv */
// Throughput: one byte item per cycle while a 64-byte block fills; each full block
// then stalls input through word prefetch, 64 rounds of the single round unit and fold.
// Last item: padding into the block store (no write when the padding reaches the
// length slot), one or two compressions, then the two digest halves in order.
// Reset (async, active low): chaining words to MD5 initial values, counts cleared;
// block store contents stay undefined until written.
`default_nettype none

module md5_byte_stream_hash (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire md5_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output md5_pkg::out_item_t      out_data_o
);

  md5_pkg::ctrl_cmd_t cmd;
  md5_pkg::dp_sts_t   sts;

  md5_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_has_byte_i (in_data_i.has_byte),
    .in_is_last_i  (in_data_i.is_last),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  md5_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_data_i.data_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
